### src/cln_pkg.sv
// ----------------------------------------------------------------------------
// cln_pkg
// Shared constants, codes and controller/datapath interface types for the
// command line normalizer.
// ----------------------------------------------------------------------------
`default_nettype none

package cln_pkg;

    localparam int LINE_STORE_DEPTH = 64;
    localparam int ADDR_W           = $clog2(LINE_STORE_DEPTH);
    localparam int CHAR_W           = 8;
    localparam int CNT_W            = 6;
    localparam int STAT_W           = 2;

    localparam logic [CNT_W-1:0]  MAX_CHARS_RST = CNT_W'(47);

    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UPA   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_LOWZ  = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

    // line status carried on the result channel
    typedef enum logic [STAT_W-1:0] {
        ST_CHAR    = 2'd0,
        ST_COMMENT = 2'd1,
        ST_REJECT  = 2'd2,
        ST_END     = 2'd3
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic take;        // input item accepted this cycle
        logic rd;          // read line store at rd index, advance index
        logic load_char;   // load output reg with store data
        logic load_pre;    // load output reg with status item
        logic load_trail;  // load output reg with closing item
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic plan_job;    // current input item produces results
        logic rd_more;     // stored chars left to emit
        logic pre_pend;    // status item precedes the closing item
        logic out_free;    // output register can take a new item
    } sts_t;

    function automatic logic is_white(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) ||
               (c == CH_FF) || (c == CH_CR);
    endfunction

    function automatic logic is_kept(input logic [CHAR_W-1:0] c);
        return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_UPA) && (c <= CH_LOWZ));
    endfunction

endpackage

`default_nettype wire

### src/cln_ram.sv
// ----------------------------------------------------------------------------
// cln_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cln_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]        wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### src/cln_dpath.sv
// ----------------------------------------------------------------------------
// cln_dpath
// Line state, character classification, emission job registers and the
// output register of the command line normalizer.
// ----------------------------------------------------------------------------
`default_nettype none

module cln_dpath (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [cln_pkg::CNT_W-1:0]   cfg_wr_data,
    input  wire logic [cln_pkg::CHAR_W-1:0]  s_tdata,
    input  wire logic [0:0]                  s_tuser,
    input  wire cln_pkg::cmd_t               cmd,
    output cln_pkg::sts_t                    sts,
    output logic                             ram_wr_en,
    output logic [cln_pkg::ADDR_W-1:0]       ram_wr_addr,
    output logic [cln_pkg::CHAR_W-1:0]       ram_wr_data,
    output logic [cln_pkg::ADDR_W-1:0]       ram_rd_addr,
    input  wire logic [cln_pkg::CHAR_W-1:0]  ram_rd_data,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [cln_pkg::CHAR_W-1:0]       m_tdata,
    output logic [cln_pkg::STAT_W-1:0]       m_tuser,
    output logic                             m_tlast
);

    import cln_pkg::*;

    typedef enum logic [1:0] {
        PH_START   = 2'd0,
        PH_LINE    = 2'd1,
        PH_COMMENT = 2'd2,
        PH_REJECT  = 2'd3
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               white_reg, white_next;
    logic [CNT_W-1:0]   max_chars_reg;

    logic [CNT_W-1:0]   keep_reg, keep_next;
    logic               pre_v_reg, pre_v_next;
    status_t            pre_st_reg, pre_st_next;
    logic [CHAR_W-1:0]  tr_char_reg, tr_char_next;
    status_t            tr_st_reg, tr_st_next;
    logic [CNT_W-1:0]   rd_idx_reg;

    logic               plan_job, plan_wr, eff_line;
    logic               c_white, c_kept, c_nl, c_hash, eoi, room, drop;

    logic               m_valid_reg;
    logic [CHAR_W-1:0]  m_data_reg;
    status_t            m_user_reg;
    logic               m_last_reg;

    assign eoi     = s_tuser[0];
    assign c_white = is_white(s_tdata);
    assign c_kept  = is_kept(s_tdata);
    assign c_nl    = (s_tdata == CH_NL);
    assign c_hash  = (s_tdata == CH_HASH);
    assign room    = (cnt_reg < max_chars_reg) && (int'(cnt_reg) < LINE_STORE_DEPTH);
    // trailing whitespace before the newline goes when the line has two+ chars
    assign drop    = (cnt_reg >= CNT_W'(2)) && white_reg;

    always_comb begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        white_next   = white_reg;
        plan_wr      = 1'b0;
        plan_job     = 1'b0;
        eff_line     = 1'b0;
        keep_next    = '0;
        pre_v_next   = 1'b0;
        pre_st_next  = ST_REJECT;
        tr_char_next = '0;
        tr_st_next   = ST_END;
        if (eoi) begin
            plan_job = 1'b1;
            case (phase_reg)
                PH_LINE: begin
                    if (white_reg) begin
                        pre_v_next = 1'b1;
                    end else begin
                        keep_next = cnt_reg;
                    end
                end
                PH_COMMENT: begin
                    pre_v_next  = 1'b1;
                    pre_st_next = ST_COMMENT;
                end
                PH_REJECT: pre_v_next = 1'b1;
                default: ;
            endcase
            phase_next = PH_START;
            cnt_next   = '0;
            white_next = 1'b0;
        end else begin
            case (phase_reg)
                PH_START: begin
                    if (c_nl) begin
                        plan_job     = 1'b1;
                        tr_char_next = CH_NL;
                        tr_st_next   = ST_CHAR;
                    end else if (c_hash) begin
                        phase_next = PH_COMMENT;
                    end else begin
                        eff_line = 1'b1;
                    end
                end
                PH_COMMENT, PH_REJECT: begin
                    if (c_nl) begin
                        plan_job   = 1'b1;
                        tr_st_next = (phase_reg == PH_COMMENT) ? ST_COMMENT : ST_REJECT;
                        phase_next = PH_START;
                        cnt_next   = '0;
                        white_next = 1'b0;
                    end
                end
                PH_LINE: eff_line = 1'b1;
                default: ;
            endcase
            if (eff_line) begin
                phase_next = PH_LINE;
                if (c_white || c_kept) begin
                    if (!(c_white && white_reg)) begin
                        if (!room) begin
                            phase_next = PH_REJECT;
                        end else begin
                            plan_wr    = 1'b1;
                            cnt_next   = cnt_reg + CNT_W'(1);
                            white_next = c_white;
                        end
                    end
                end else if (c_nl) begin
                    plan_job = 1'b1;
                    if (!room) begin
                        tr_st_next = ST_REJECT;
                    end else begin
                        keep_next    = cnt_reg - CNT_W'(drop);
                        tr_char_next = CH_NL;
                        tr_st_next   = ST_CHAR;
                    end
                    phase_next = PH_START;
                    cnt_next   = '0;
                    white_next = 1'b0;
                end else begin
                    phase_next = PH_REJECT;
                end
            end
        end
    end

    // line state and config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_START;
            cnt_reg       <= '0;
            white_reg     <= 1'b0;
            max_chars_reg <= MAX_CHARS_RST;
        end else begin
            if (cmd.take) begin
                phase_reg <= phase_next;
                cnt_reg   <= cnt_next;
                white_reg <= white_next;
            end
            if (cfg_wr_en) begin
                max_chars_reg <= cfg_wr_data;
            end
        end
    end

    // emission job
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_reg   <= '0;
            pre_v_reg  <= 1'b0;
            rd_idx_reg <= '0;
        end else begin
            if (cmd.take) begin
                keep_reg   <= keep_next;
                pre_v_reg  <= pre_v_next;
                rd_idx_reg <= '0;
            end else if (cmd.rd) begin
                rd_idx_reg <= rd_idx_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            pre_st_reg  <= pre_st_next;
            tr_char_reg <= tr_char_next;
            tr_st_reg   <= tr_st_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_char || cmd.load_pre || cmd.load_trail) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_char) begin
            m_data_reg <= ram_rd_data;
            m_user_reg <= ST_CHAR;
            m_last_reg <= 1'b0;
        end else if (cmd.load_pre) begin
            m_data_reg <= '0;
            m_user_reg <= pre_st_reg;
            m_last_reg <= 1'b0;
        end else if (cmd.load_trail) begin
            m_data_reg <= tr_char_reg;
            m_user_reg <= tr_st_reg;
            m_last_reg <= 1'b1;
        end
    end

    assign sts.plan_job = plan_job;
    assign sts.rd_more  = (rd_idx_reg != keep_reg);
    assign sts.pre_pend = pre_v_reg;
    assign sts.out_free = !m_valid_reg || m_tready;

    assign ram_wr_en   = cmd.take && plan_wr;
    assign ram_wr_addr = ADDR_W'(cnt_reg);
    assign ram_wr_data = s_tdata;
    assign ram_rd_addr = ADDR_W'(rd_idx_reg);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

### src/cln_ctrl.sv
// ----------------------------------------------------------------------------
// cln_ctrl
// Emission sequencer: takes input items and steps through stored line
// characters, an optional status item and the closing item.
// ----------------------------------------------------------------------------
`default_nettype none

module cln_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire cln_pkg::sts_t  sts,
    output cln_pkg::cmd_t       cmd
);

    import cln_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NEXT,
        S_CHAR,
        S_PRE,
        S_TRAIL
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                cmd.take = s_tvalid;
                if (s_tvalid && sts.plan_job) begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT: begin
                if (sts.rd_more) begin
                    cmd.rd     = 1'b1;
                    state_next = S_CHAR;
                end else if (sts.pre_pend) begin
                    state_next = S_PRE;
                end else begin
                    state_next = S_TRAIL;
                end
            end
            S_CHAR: begin
                if (sts.out_free) begin
                    cmd.load_char = 1'b1;
                    state_next    = S_NEXT;
                end
            end
            S_PRE: begin
                if (sts.out_free) begin
                    cmd.load_pre = 1'b1;
                    state_next   = S_TRAIL;
                end
            end
            S_TRAIL: begin
                if (sts.out_free) begin
                    cmd.load_trail = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

`default_nettype wire

### src/command_line_normalizer.sv
// ----------------------------------------------------------------------------
// command_line_normalizer
// Normalizes a byte stream of command lines: collapses whitespace runs,
// drops comments, rejects bad or overlong lines and emits each line with a
// per-item status.
// ----------------------------------------------------------------------------
//
//  channel   dir   tdata            tuser               tlast
//  s_*       in    in_byte[7:0]     end_of_input[0]     -
//  m_*       out   out_char[7:0]    line_status[1:0]    last of a step
//  cfg_*     in    max_chars[5:0] on cfg_wr_data, written when cfg_wr_en
//
//  An item that closes a line is accepted, then each emitted stored
//  character is read from the line store and then loaded into the output
//  register, followed by the optional status item and the closing item;
//  the single-read-port line store sets this. While results are being
//  emitted s_tready is low; a stalled m_tready holds the sequencer in
//  place. Reset needs no clearing pass: only entries written in the
//  current line are ever read.
//
`default_nettype none

module command_line_normalizer (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // config: max_chars
    input  wire logic                        cfg_wr_en,
    input  wire logic [cln_pkg::CNT_W-1:0]   cfg_wr_data,
    // input items
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [cln_pkg::CHAR_W-1:0]  s_tdata,   // [7:0] in_byte
    input  wire logic [0:0]                  s_tuser,   // [0] end_of_input
    // result items
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [cln_pkg::CHAR_W-1:0]       m_tdata,   // [7:0] out_char
    output logic [cln_pkg::STAT_W-1:0]       m_tuser,   // [1:0] line_status
    output logic                             m_tlast
);

    import cln_pkg::*;

    cmd_t               cmd;
    sts_t               sts;
    logic               ram_wr_en;
    logic [ADDR_W-1:0]  ram_wr_addr;
    logic [CHAR_W-1:0]  ram_wr_data;
    logic [ADDR_W-1:0]  ram_rd_addr;
    logic [CHAR_W-1:0]  ram_rd_data;

    // sequencer: accept, then walk the emission job
    cln_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // line state, classification, job registers, output register
    cln_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cmd         (cmd),
        .sts         (sts),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // line store: written on accept, read one entry per emitted character
    cln_ram #(
        .DATA_W (CHAR_W),
        .DEPTH  (LINE_STORE_DEPTH)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.rd),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

`default_nettype wire

### bench/command_line_normalizer_tb.sv
// ----------------------------------------------------------------------------
// command_line_normalizer_tb
// Self-checking bench for the command line normalizer. A line-by-line
// predictor mirrors the line state and the max_chars register. Directed rows
// come first, then random command streams under three idling mixes and three
// max_chars settings, with one long output stall. Every result item is checked.
// ----------------------------------------------------------------------------
`default_nettype none

module command_line_normalizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cln_pkg::*;

    localparam int QUIET_LIMIT  = 3000;  // cycles with no item moving on either side
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_CYCLES  = 400;

    // one result item as seen on the m_ side
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        status_t           st;
        logic              is_last;
    } line_item_t;

    // where the predictor stands within the current line
    typedef enum logic [1:0] {
        LN_START,
        LN_BODY,
        LN_COMMENT,
        LN_SKIP
    } line_phase_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    // directed row: an item, or a max_chars write (value in data)
    typedef struct packed {
        row_kind_t         kind;
        logic [CHAR_W-1:0] data;
        logic              eoi;
        logic              typed;   // result typed in below, not taken from the predictor
        logic [CHAR_W-1:0] exp_ch;
        status_t           exp_st;
    } dir_row_t;

    logic aclk = 1'b0;
    logic aresetn;

    logic              cfg_wr_en;
    logic [CNT_W-1:0]  cfg_wr_data;

    logic              s_tvalid;
    logic              s_tready;
    logic [CHAR_W-1:0] s_tdata;   // [7:0] in_byte
    logic [0:0]        s_tuser;   // [0] end_of_input

    logic              m_tvalid;
    logic              m_tready;
    logic [CHAR_W-1:0] m_tdata;   // [7:0] out_char
    logic [STAT_W-1:0] m_tuser;   // [1:0] line_status
    logic              m_tlast;

    // predictor state
    logic [CHAR_W-1:0] line_buf [LINE_STORE_DEPTH];
    int unsigned       line_len;
    line_phase_t       line_phase;
    logic              white_run;
    int unsigned       max_chars_q;

    line_item_t  step_items [$];   // results of the item just accepted
    line_item_t  items_due  [$];   // results still to come out of the block
    dir_row_t    dir_tab    [$];

    int unsigned fail_count;
    int unsigned items_sent;
    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;
    int unsigned quiet_cycles;
    logic        stall_req;
    logic        stall_done;

    command_line_normalizer u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic logic white_char(input logic [CHAR_W-1:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR;
    endfunction

    function automatic logic word_char(input logic [CHAR_W-1:0] c);
        return (c >= CH_0 && c <= CH_9) || (c >= CH_UPA && c <= CH_LOWZ);
    endfunction

    function automatic void push_result(input logic [CHAR_W-1:0] ch, input status_t st);
        line_item_t it;
        it.ch      = ch;
        it.st      = st;
        it.is_last = 1'b0;
        step_items.push_back(it);
    endfunction

    // a store needs room under both the register and the store depth
    function automatic logic line_has_room();
        return line_len < max_chars_q && line_len < LINE_STORE_DEPTH;
    endfunction

    function automatic void open_line();
        line_phase = LN_START;
        line_len   = 0;
        white_run  = 1'b0;
    endfunction

    // Advance the line state by one accepted item; results land in step_items.
    task automatic normalize_byte(input logic [CHAR_W-1:0] c, input logic eoi);
        logic        taken;
        logic        ws;
        int unsigned keep;
        taken = 1'b0;
        step_items.delete();
        if (eoi) begin
            // close whatever is pending, then mark the end of the stream
            case (line_phase)
                LN_BODY: begin
                    if (white_run) begin
                        push_result('0, ST_REJECT);
                    end else begin
                        for (int unsigned i = 0; i < line_len; i++)
                            push_result(line_buf[i], ST_CHAR);
                    end
                end
                LN_COMMENT: push_result('0, ST_COMMENT);
                LN_SKIP:    push_result('0, ST_REJECT);
                default: ;
            endcase
            push_result('0, ST_END);
            open_line();
        end else begin
            if (line_phase == LN_START) begin
                if (c == CH_NL) begin
                    push_result(c, ST_CHAR);   // empty line, no length check
                    taken = 1'b1;
                end else if (c == CH_HASH) begin
                    line_phase = LN_COMMENT;
                    taken = 1'b1;
                end else begin
                    line_phase = LN_BODY;
                    line_len   = 0;
                    white_run  = 1'b0;
                end
            end
            if (!taken) begin
                case (line_phase)
                    LN_COMMENT: begin
                        if (c == CH_NL) begin
                            push_result('0, ST_COMMENT);
                            open_line();
                        end
                    end
                    LN_SKIP: begin
                        if (c == CH_NL) begin
                            push_result('0, ST_REJECT);
                            open_line();
                        end
                    end
                    LN_BODY: begin
                        ws = white_char(c);
                        if (ws || word_char(c)) begin
                            // a whitespace run keeps only its first character
                            if (!(ws && white_run)) begin
                                if (!line_has_room()) begin
                                    line_phase = LN_SKIP;
                                end else begin
                                    line_buf[line_len] = c;
                                    line_len++;
                                    white_run = ws;
                                end
                            end
                        end else if (c == CH_NL) begin
                            if (!line_has_room()) begin
                                push_result('0, ST_REJECT);
                            end else begin
                                // one trailing whitespace goes when the line is long enough
                                keep = line_len;
                                if (keep >= 2 && white_char(line_buf[keep-1]))
                                    keep--;
                                for (int unsigned i = 0; i < keep; i++)
                                    push_result(line_buf[i], ST_CHAR);
                                push_result(CH_NL, ST_CHAR);
                            end
                            open_line();
                        end else begin
                            line_phase = LN_SKIP;
                        end
                    end
                    default: ;
                endcase
            end
        end
        if (step_items.size() > 0)
            step_items[step_items.size()-1].is_last = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // Offer one item, idle before it at the current rate, wait for acceptance.
    task automatic offer_item(input logic [CHAR_W-1:0] b, input logic eoi);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= eoi;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        items_sent++;
        normalize_byte(b, eoi);
    endtask

    task automatic send_item(input logic [CHAR_W-1:0] b, input logic eoi);
        offer_item(b, eoi);
        foreach (step_items[i])
            items_due.push_back(step_items[i]);
    endtask

    // Block idle: every expected result out, then a settle wait for any
    // item that only touched line state.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (items_due.size() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_max_chars(input int unsigned value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CNT_W'(value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        max_chars_q = value;
    endtask

    // whitespace 30%, otherwise a kept character
    function automatic logic [CHAR_W-1:0] pick_line_char();
        if ($urandom_range(99) < 30) begin
            case ($urandom_range(4))
                0:       return CH_SPACE;
                1:       return CH_TAB;
                2:       return CH_VT;
                3:       return CH_FF;
                default: return CH_CR;
            endcase
        end
        if ($urandom_range(3) == 0)
            return CHAR_W'($urandom_range(CH_0, CH_9));
        return CHAR_W'($urandom_range(CH_UPA, CH_LOWZ));
    endfunction

    // Random command stream: mostly well-formed lines with random content,
    // some comments, empty lines and ends of input, the rest broken or noise.
    task automatic run_random(input int unsigned quota);
        int unsigned goal;
        int unsigned kind;
        int unsigned len;
        int unsigned bad_at;
        logic [CHAR_W-1:0] b;
        goal = items_sent + quota;
        while (items_sent < goal) begin
            kind = $urandom_range(99);
            if (kind < 60 || (kind >= 85 && kind < 93)) begin
                // short lines mostly, some around and past the limit
                len = ($urandom_range(9) < 7) ? $urandom_range(0, 8)
                                              : $urandom_range(0, max_chars_q + 2);
                bad_at = (kind >= 85) ? $urandom_range(0, len) : len + 1;
                for (int unsigned i = 0; i <= len; i++) begin
                    if (i == bad_at)
                        send_item(CHAR_W'($urandom_range(255)), 1'b0);
                    if (i < len)
                        send_item(pick_line_char(), 1'b0);
                end
                if ($urandom_range(99) < 85)
                    send_item(CH_NL, 1'b0);
                else
                    send_item(CHAR_W'($urandom_range(255)), 1'b1);
            end else if (kind < 70) begin
                send_item(CH_HASH, 1'b0);
                len = $urandom_range(0, 6);
                for (int unsigned i = 0; i < len; i++) begin
                    b = CHAR_W'($urandom_range(255));
                    send_item((b == CH_NL) ? CH_HASH : b, 1'b0);
                end
                send_item(CH_NL, $urandom_range(9) == 0);
            end else if (kind < 78) begin
                send_item(CH_NL, 1'b0);
            end else if (kind < 85) begin
                send_item(CHAR_W'($urandom_range(255)), 1'b1);
            end else begin
                len = $urandom_range(1, 8);
                for (int unsigned i = 0; i < len; i++)
                    send_item(CHAR_W'($urandom_range(255)), $urandom_range(9) == 0);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: random ready, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_req && !stall_done) begin
                m_tready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge aclk);
                stall_done = 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // Each accepted result against the oldest expectation.
    always @(posedge aclk) begin
        line_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (items_due.size() == 0) begin
                $error("result item with nothing expected: out_char %h status %0d last %b",
                       m_tdata, m_tuser, m_tlast);
                fail_count++;
            end else begin
                want = items_due.pop_front();
                if (m_tdata !== want.ch) begin
                    $error("out_char: expected %h, got %h", want.ch, m_tdata);
                    fail_count++;
                end
                if (m_tuser !== want.st) begin
                    $error("line_status: expected %0d, got %0d", want.st, m_tuser);
                    fail_count++;
                end
                if (m_tlast !== want.is_last) begin
                    $error("last: expected %b, got %b", want.is_last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: nothing moving on either side for too long ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        dir_row_t row;
        aresetn      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_data  <= '0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= '0;
        fail_count   = 0;
        items_sent   = 0;
        quiet_cycles = 0;
        stall_req    = 1'b0;
        stall_done   = 1'b0;
        src_idle_pct = 36;
        snk_idle_pct = 46;
        max_chars_q  = MAX_CHARS_RST;
        open_line();

        // Directed rows. First ones run on the reset value of max_chars.
        //                 kind      data      eoi   typed exp_ch    exp_st
        dir_tab.push_back('{ROW_ITEM, CH_NL,    1'b0, 1'b1, CH_NL,    ST_CHAR});    // empty line
        dir_tab.push_back('{ROW_ITEM, 8'h00,    1'b1, 1'b1, 8'h00,    ST_END});     // bare end
        dir_tab.push_back('{ROW_ITEM, CH_HASH,  1'b0, 1'b0, 8'h00,    ST_CHAR});    // comment opens
        dir_tab.push_back('{ROW_ITEM, 8'hFF,    1'b0, 1'b0, 8'h00,    ST_CHAR});    // skipped
        dir_tab.push_back('{ROW_ITEM, CH_NL,    1'b0, 1'b1, 8'h00,    ST_COMMENT});
        dir_tab.push_back('{ROW_ITEM, CH_UPA,   1'b0, 1'b0, 8'h00,    ST_CHAR});
        dir_tab.push_back('{ROW_ITEM, CH_SPACE, 1'b0, 1'b0, 8'h00,    ST_CHAR});
        dir_tab.push_back('{ROW_ITEM, CH_TAB,   1'b0, 1'b0, 8'h00,    ST_CHAR});    // run collapses
        dir_tab.push_back('{ROW_ITEM, CH_LOWZ,  1'b0, 1'b0, 8'h00,    ST_CHAR});
        dir_tab.push_back('{ROW_ITEM, CH_CR,    1'b0, 1'b0, 8'h00,    ST_CHAR});    // trimmed
        dir_tab.push_back('{ROW_ITEM, CH_NL,    1'b0, 1'b0, 8'h00,    ST_CHAR});
        dir_tab.push_back('{ROW_ITEM, CH_0,     1'b0, 1'b0, 8'h00,    ST_CHAR});
        dir_tab.push_back('{ROW_ITEM, CH_9,     1'b0, 1'b0, 8'h00,    ST_CHAR});
        dir_tab.push_back('{ROW_ITEM, CH_VT,    1'b0, 1'b0, 8'h00,    ST_CHAR});
        dir_tab.push_back('{ROW_ITEM, 8'hA5,    1'b1, 1'b0, 8'h00,    ST_CHAR});    // white, then end
        dir_tab.push_back('{ROW_ITEM, 8'h7B,    1'b0, 1'b0, 8'h00,    ST_CHAR});    // just past 'z'
        dir_tab.push_back('{ROW_ITEM, CH_NL,    1'b0, 1'b1, 8'h00,    ST_REJECT});
        dir_tab.push_back('{ROW_CFG,  8'd1,     1'b0, 1'b0, 8'h00,    ST_CHAR});
        dir_tab.push_back('{ROW_ITEM, 8'h61,    1'b0, 1'b0, 8'h00,    ST_CHAR});    // fills the line
        dir_tab.push_back('{ROW_ITEM, 8'h62,    1'b0, 1'b0, 8'h00,    ST_CHAR});    // no room
        dir_tab.push_back('{ROW_ITEM, CH_NL,    1'b0, 1'b1, 8'h00,    ST_REJECT});
        dir_tab.push_back('{ROW_ITEM, 8'h40,    1'b0, 1'b0, 8'h00,    ST_CHAR});    // just below 'A'
        dir_tab.push_back('{ROW_ITEM, 8'h00,    1'b1, 1'b0, 8'h00,    ST_CHAR});
        dir_tab.push_back('{ROW_CFG,  8'd63,    1'b0, 1'b0, 8'h00,    ST_CHAR});
        dir_tab.push_back('{ROW_ITEM, CH_FF,    1'b0, 1'b0, 8'h00,    ST_CHAR});    // short white line
        dir_tab.push_back('{ROW_ITEM, CH_NL,    1'b0, 1'b0, 8'h00,    ST_CHAR});
        dir_tab.push_back('{ROW_ITEM, 8'h78,    1'b0, 1'b0, 8'h00,    ST_CHAR});
        dir_tab.push_back('{ROW_ITEM, 8'h00,    1'b1, 1'b0, 8'h00,    ST_CHAR});    // open line at end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i]) begin
            row = dir_tab[i];
            if (row.kind == ROW_CFG) begin
                write_max_chars(row.data);
            end else if (row.typed) begin
                offer_item(row.data, row.eoi);
                items_due.push_back('{row.exp_ch, row.exp_st, 1'b1});
            end else begin
                send_item(row.data, row.eoi);
            end
        end

        // sender idles less than receiver
        write_max_chars(12);
        run_random(150);

        // the other way round
        src_idle_pct = 46;
        snk_idle_pct = 36;
        write_max_chars(63);
        run_random(150);

        // full rate, with one long output hold-off so the input backs up
        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_max_chars(5);
        stall_req = 1'b1;
        run_random(150);

        drain_results();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
